// ===== src/ita_pkg.sv =====
`default_nettype none

package ita_pkg;

  // Command codes
  localparam logic [1:0] CMD_UDEC = 2'd0;
  localparam logic [1:0] CMD_SDEC = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;
  localparam logic [1:0] CMD_OCT  = 2'd3;

  // Digit store: 22 nibbles, enough for the longest octal text
  localparam int VALUE_W     = 64;
  localparam int DIGITS      = 22;
  localparam int DIG_W       = 4;
  localparam int POS_W       = 5;
  localparam int BCD_DIGITS  = 20;
  localparam int CONV_BITS   = 4;
  localparam int CONV_CYCLES = VALUE_W / CONV_BITS;
  localparam int CNT_W       = 4;

  // Highest digit position scanned for each radix
  localparam logic [POS_W-1:0] TOP_DEC = 5'd19;
  localparam logic [POS_W-1:0] TOP_HEX = 5'd15;
  localparam logic [POS_W-1:0] TOP_OCT = 5'd21;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_ALPHA = 8'h57;  // 'a' minus ten

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } ita_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_dec;
    logic negative;
    logic pos_zero;
  } ita_stat_t;

  // Map one digit to its ASCII character
  function automatic logic [7:0] to_ascii(input logic [DIG_W-1:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = ASCII_ZERO + {4'b0000, d};
    end else begin
      r = ASCII_ALPHA + {4'b0000, d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ita_datapath.sv =====
`default_nettype none

module ita_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [ita_pkg::VALUE_W-1:0]          value,
  input  wire logic [1:0]                           command,
  input  wire ita_pkg::ita_ctrl_t                   ctrl,
  output ita_pkg::ita_stat_t                        stat,
  output logic                                      strobe,
  output logic [7:0]                                char_code,
  output logic                                      last
);

  localparam int DW = ita_pkg::DIGITS * ita_pkg::DIG_W;
  localparam int BW = ita_pkg::BCD_DIGITS * ita_pkg::DIG_W;

  logic [DW-1:0]                   dig;
  logic [DW-1:0]                   dig_load;
  logic [BW-1:0]                   bcd_next;
  logic [ita_pkg::VALUE_W-1:0]     src;
  logic [ita_pkg::VALUE_W-1:0]     mag;
  logic [ita_pkg::VALUE_W+1:0]     val_ext;
  logic [ita_pkg::POS_W-1:0]       pos;
  logic [ita_pkg::POS_W-1:0]       pos_load;
  logic                            neg;
  logic                            neg_in;
  logic                            started;
  logic [ita_pkg::DIG_W-1:0]       cur;
  logic                            show;

  // Decode the incoming request
  assign neg_in  = (command == ita_pkg::CMD_SDEC) && value[ita_pkg::VALUE_W-1];
  assign mag     = neg_in ? (~value + 64'd1) : value;
  assign val_ext = {2'b00, value};

  always_comb begin
    dig_load = '0;
    pos_load = ita_pkg::TOP_DEC;
    case (command)
      ita_pkg::CMD_HEX: begin
        dig_load = {{(DW - ita_pkg::VALUE_W){1'b0}}, value};
        pos_load = ita_pkg::TOP_HEX;
      end
      ita_pkg::CMD_OCT: begin
        for (int i = 0; i < ita_pkg::DIGITS; i++) begin
          dig_load[i*ita_pkg::DIG_W +: ita_pkg::DIG_W] = {1'b0, val_ext[i*3 +: 3]};
        end
        pos_load = ita_pkg::TOP_OCT;
      end
      default: begin
        dig_load = '0;
        pos_load = ita_pkg::TOP_DEC;
      end
    endcase
  end

  // Shift-add-3 conversion, four source bits per cycle
  always_comb begin
    bcd_next = dig[BW-1:0];
    for (int s = 0; s < ita_pkg::CONV_BITS; s++) begin
      for (int i = 0; i < ita_pkg::BCD_DIGITS; i++) begin
        if (bcd_next[i*ita_pkg::DIG_W +: ita_pkg::DIG_W] >= 4'd5) begin
          bcd_next[i*ita_pkg::DIG_W +: ita_pkg::DIG_W] =
            bcd_next[i*ita_pkg::DIG_W +: ita_pkg::DIG_W] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BW-2:0], src[ita_pkg::VALUE_W-1-s]};
    end
  end

  // Current digit and leading-zero suppression
  assign cur  = dig[{pos, 2'b00} +: ita_pkg::DIG_W];
  assign show = started || (cur != 4'd0) || (pos == '0);

  // Digit store, source shifter and scan pointer
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dig <= dig_load;
      src <= mag;
      neg <= neg_in;
      pos <= pos_load;
    end else if (ctrl.conv_step) begin
      dig <= {{(DW - BW){1'b0}}, bcd_next};
      src <= {src[ita_pkg::VALUE_W-1-ita_pkg::CONV_BITS:0], {ita_pkg::CONV_BITS{1'b0}}};
    end else if (ctrl.emit_digit) begin
      pos <= pos - 5'd1;
    end
  end

  // Track whether a significant digit has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (ctrl.load) begin
      started <= 1'b0;
    end else if (ctrl.emit_digit && (cur != 4'd0)) begin
      started <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit_sign || (ctrl.emit_digit && show);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_sign) begin
      char_code <= ita_pkg::ASCII_MINUS;
      last      <= 1'b0;
    end else begin
      char_code <= ita_pkg::to_ascii(cur);
      last      <= (pos == '0);
    end
  end

  // Status back to the controller
  assign stat.in_dec   = (command == ita_pkg::CMD_UDEC) || (command == ita_pkg::CMD_SDEC);
  assign stat.negative = neg;
  assign stat.pos_zero = (pos == '0);

endmodule

`default_nettype wire

// ===== src/ita_ctrl.sv =====
`default_nettype none

module ita_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ita_pkg::ita_stat_t stat,
  output ita_pkg::ita_ctrl_t      ctrl,
  output logic                    busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [ita_pkg::CNT_W-1:0] CNT_LAST = ita_pkg::CNT_W'(ita_pkg::CONV_CYCLES - 1);

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [ita_pkg::CNT_W-1:0] cnt;
  logic [ita_pkg::CNT_W-1:0] cnt_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = stat.in_dec ? S_CONV : S_EMIT;
        end
      end
      S_CONV: begin
        ctrl.conv_step = 1'b1;
        cnt_next       = cnt + 4'd1;
        if (cnt == CNT_LAST) begin
          state_next = stat.negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        ctrl.emit_sign = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        ctrl.emit_digit = 1'b1;
        if (stat.pos_zero) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
// Decimal first converts the value four bits at a time, then scans 20 digit
// slots one a cycle; hex and octal skip the conversion and scan 16 or 22 slots
// the same way. Leading zeros use a slot with no strobe; a negative decimal
// value sends its minus sign before the digits. A new request is taken only
// once the block is idle again; the receiver cannot stall.
// Reset: synchronous, active high; returns to idle and drops the strobe.
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ita_pkg::VALUE_W-1:0] value,
  input  wire logic [1:0]                  command,
  output logic                             strobe,
  output logic [7:0]                       char_code,
  output logic                             last
);

  ita_pkg::ita_ctrl_t ctrl;
  ita_pkg::ita_stat_t stat;

  // Sequencer
  ita_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Conversion and output datapath
  ita_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .command   (command),
    .ctrl      (ctrl),
    .stat      (stat),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== src/ita_checker.sv =====
`default_nettype none

module ita_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [7:0] char_code,
  input wire logic       last
);

  // A request taken keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // Final character arrives as the block frees up
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("busy still high on final character");

  // Non-final characters only while working
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("character outside of a request");

  // Idle with no request produces nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !strobe)
    else $error("spurious character");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == ita_pkg::ASCII_MINUS)) |-> !last)
    else $error("text ends in minus sign");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .char_code (char_code),
  .last      (last)
);

`default_nettype wire
